@@ src/lcdcg_pkg.sv @@
// Shared types, request codes and display constants for the LCD command generator.
`default_nettype none

package lcdcg_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIGITS  = 5;
    localparam int unsigned BCD_W   = 4 * DIGITS;
    localparam int unsigned DD_W    = BCD_W + VALUE_W;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned STEPS_PER_STAGE = VALUE_W / 2;

    // Request codes.
    localparam logic [OP_W-1:0] OP_CHAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_RAW    = 3'd1;
    localparam logic [OP_W-1:0] OP_GOTO_L = 3'd2;
    localparam logic [OP_W-1:0] OP_GOTO_S = 3'd3;
    localparam logic [OP_W-1:0] OP_NUMBER = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd6;

    // Register select codes.
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Display commands.
    localparam logic [BYTE_W-1:0] CMD_FUNC_SET = 8'h38;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_HOME_POS = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'd48;

    // Cursor address offsets, already reduced by the first position of each row.
    localparam logic [BYTE_W-1:0] OFS_L_ROW4 = 8'(8'hD4 - 8'd61);
    localparam logic [BYTE_W-1:0] OFS_L_ROW3 = 8'(8'h94 - 8'd41);
    localparam logic [BYTE_W-1:0] OFS_L_ROW2 = 8'(8'hC0 - 8'd21);
    localparam logic [BYTE_W-1:0] OFS_S_ROW2 = 8'(8'hC0 - 8'd17);
    localparam logic [BYTE_W-1:0] OFS_ROW1   = 8'(8'h80 - 8'd1);

    localparam logic [BYTE_W-1:0] LIM_L_ROW4 = 8'd60;
    localparam logic [BYTE_W-1:0] LIM_L_ROW3 = 8'd40;
    localparam logic [BYTE_W-1:0] LIM_L_ROW2 = 8'd20;
    localparam logic [BYTE_W-1:0] LIM_S_ROW2 = 8'd16;

    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_CLEAR = 3'd2;
    localparam logic [CNT_W-1:0] CNT_INIT  = 3'd4;

    typedef logic [DIGITS-1:0][BYTE_W-1:0] t_bytes;

    // One request in flight: dd holds the BCD digits above the binary bits still to shift.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] low;
        logic [DD_W-1:0]   dd;
    } t_item;

    // One shift-and-add-3 step of the binary to BCD conversion.
    function automatic logic [DD_W-1:0] dabble_step(input logic [DD_W-1:0] dd);
        logic [DD_W-1:0] adj;
        adj = dd;
        for (int k = 0; k < DIGITS; k++) begin
            if (adj[VALUE_W + 4*k +: 4] > 4'd4) begin
                adj[VALUE_W + 4*k +: 4] = adj[VALUE_W + 4*k +: 4] + 4'd3;
            end
        end
        return {adj[DD_W-2:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ src/lcdcg_bcd_stage.sv @@
// Pipeline stage that runs half of the binary to BCD conversion on one request.
`default_nettype none

module lcdcg_bcd_stage
    import lcdcg_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item = i_item;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            n_item.dd = dabble_step(n_item.dd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    // A word held back by the next stage must not change under it.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_item)))
        else $error("bcd stage changed a stalled word");

endmodule

`default_nettype wire

@@ src/lcdcg_emit.sv @@
// Formats a converted request into its list of display writes and sends them one a cycle while i_ready is high.
`default_nettype none

module lcdcg_emit
    import lcdcg_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_item        i_item,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [BYTE_W-1:0] o_write_byte,
    output logic              o_reg_select,
    output logic              o_last
);

    t_bytes             r_buf;
    logic               r_rs;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic               r_busy;

    t_bytes             n_buf;
    logic               n_rs;
    logic [CNT_W-1:0]   n_cnt;

    logic [DIGITS-1:0][3:0] dig;
    logic [CNT_W-1:0]       ndig;
    logic [BYTE_W-1:0]      p;
    logic                   load;

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            dig[k] = i_item.dd[VALUE_W + 4*k +: 4];
        end
        if (dig[4] != 4'd0) begin
            ndig = 3'd5;
        end else if (dig[3] != 4'd0) begin
            ndig = 3'd4;
        end else if (dig[2] != 4'd0) begin
            ndig = 3'd3;
        end else if (dig[1] != 4'd0) begin
            ndig = 3'd2;
        end else begin
            ndig = 3'd1;
        end
    end

    always_comb begin
        logic [CNT_W-1:0] k;
        k     = '0;
        p     = i_item.low;
        n_buf = '0;
        n_rs  = RS_CMD;
        n_cnt = '0;
        case (i_item.op)
            OP_CHAR: begin
                n_buf[0] = p;
                n_rs     = RS_DATA;
                n_cnt    = CNT_ONE;
            end
            OP_RAW: begin
                n_buf[0] = p;
                n_cnt    = CNT_ONE;
            end
            OP_GOTO_L: begin
                if (p > LIM_L_ROW4) begin
                    n_buf[0] = p + OFS_L_ROW4;
                end else if (p > LIM_L_ROW3) begin
                    n_buf[0] = p + OFS_L_ROW3;
                end else if (p > LIM_L_ROW2) begin
                    n_buf[0] = p + OFS_L_ROW2;
                end else begin
                    n_buf[0] = p + OFS_ROW1;
                end
                n_cnt = CNT_ONE;
            end
            OP_GOTO_S: begin
                if (p > LIM_S_ROW2) begin
                    n_buf[0] = p + OFS_S_ROW2;
                end else begin
                    n_buf[0] = p + OFS_ROW1;
                end
                n_cnt = CNT_ONE;
            end
            OP_NUMBER: begin
                // Most significant kept digit goes out first.
                for (int i = 0; i < DIGITS; i++) begin
                    k = 3'(ndig - 3'd1 - 3'(i));
                    if (3'(i) < ndig) begin
                        n_buf[i] = ASCII_ZERO + {4'd0, dig[k]};
                    end
                end
                n_rs  = RS_DATA;
                n_cnt = ndig;
            end
            OP_CLEAR: begin
                n_buf[0] = CMD_CLEAR;
                n_buf[1] = CMD_HOME_POS;
                n_cnt    = CNT_CLEAR;
            end
            OP_INIT: begin
                n_buf[0] = CMD_FUNC_SET;
                n_buf[1] = CMD_DISP_ON;
                n_buf[2] = CMD_CLEAR;
                n_buf[3] = CMD_HOME_POS;
                n_cnt    = CNT_INIT;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign o_valid      = r_busy;
    assign o_write_byte = r_buf[r_idx];
    assign o_reg_select = r_rs;
    assign o_last       = (r_idx == r_cnt - CNT_ONE);
    assign o_ready      = !r_busy || (i_ready && o_last);
    assign load         = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= (n_cnt != '0);
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + CNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= n_buf;
            r_rs  <= n_rs;
            r_cnt <= n_cnt;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= 3'd5 && r_idx < r_cnt))
        else $error("emitter index outside its write list");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_valid && r_idx == $past(r_idx) + CNT_ONE))
        else $error("emitter skipped or repeated a write");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last && !i_valid) |=> !o_valid)
        else $error("emitter kept going after the last write");

endmodule

`default_nettype wire

@@ src/char_lcd_command_generator.sv @@
// Top level of the character LCD command generator: two conversion stages and the emitter.
//
//   channel | direction | fields                            | handshake
//   --------+-----------+-----------------------------------+-------------------
//   request | in        | i_op, i_value                     | i_valid / o_ready
//   write   | out       | o_write_byte, o_reg_select, o_last | o_valid / i_ready
//
// A request passes two register stages of the decimal conversion and is then loaded into
// the emitter, which drives its first word from its own registers.
// The emitter sends one word a cycle while i_ready is high, so a request producing n words
// (one to five) holds it until its last word is taken; a request producing none does not.
// Reset clears the stage valid bits and the emitter busy flag and index only.
// While the output stalls, the emitter holds its word and the stages behind it fill and
// then drop o_ready.
`default_nettype none

module char_lcd_command_generator
    import lcdcg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [VALUE_W-1:0]  i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [BYTE_W-1:0]        o_write_byte,
    output logic                     o_reg_select,
    output logic                     o_last
);

    t_item in_item;
    t_item s1_item;
    t_item s2_item;
    logic  s1_valid;
    logic  s1_ready;
    logic  s2_valid;
    logic  s2_ready;

    always_comb begin
        in_item.op  = i_op;
        in_item.low = i_value[BYTE_W-1:0];
        in_item.dd  = {{BCD_W{1'b0}}, i_value};
    end

    lcdcg_bcd_stage u_bcd_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_item  (s1_item)
    );

    lcdcg_bcd_stage u_bcd_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_item  (s1_item),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_item  (s2_item)
    );

    lcdcg_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s2_valid),
        .o_ready      (s2_ready),
        .i_item       (s2_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_write_byte (o_write_byte),
        .o_reg_select (o_reg_select),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
